FILE: hdl/mmpid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and arithmetic helpers of the multi-mode PID controller.
// No dependencies; every other file of the block imports this package.
package mmpid_pkg;

   localparam int DATA_W    = 32;
   localparam int LIMIT_W   = 31;
   localparam int CSR_IDX_W = 3;
   localparam int DIV_STEPS = 48;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // Request modes.
   localparam logic [1:0] MODE_POSITIONAL  = 2'd0;
   localparam logic [1:0] MODE_INCREMENTAL = 2'd1;
   localparam logic [1:0] MODE_DERIV_MEAS  = 2'd2;
   localparam logic [1:0] MODE_FEEDFWD     = 2'd3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_HIGH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_LOW     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_PERIOD  = 3'd6;

   localparam logic signed [DATA_W-1:0]  RST_OUTPUT_HIGH = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0]  RST_OUTPUT_LOW  = 32'sh8000_0000;
   localparam logic [LIMIT_W-1:0]        RST_LIMIT       = 31'h7FFF_FFFF;
   localparam logic [LIMIT_W-1:0]        RST_PERIOD      = 31'd655;
   // Fixed 0.01 gain of the incremental mode in Q16.16.
   localparam logic signed [DATA_W-1:0]  INC_GAIN        = 32'sd655;

   localparam logic signed [63:0] S32_MAX_W = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] S32_MIN_W = 64'shFFFF_FFFF_8000_0000;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ERR, ST_P_MUL, ST_P_WB, ST_Q_MUL, ST_Q_WB, ST_INTEG,
      ST_I_MUL, ST_I_WB, ST_DIFF, ST_DIV_INIT, ST_DIV_STEP, ST_RATE,
      ST_D_MUL, ST_D_WB, ST_NEG, ST_SUM, ST_FF, ST_UPD, ST_PUT,
      ST_IDIFF, ST_IP_MUL, ST_IP_WB, ST_IT_MUL, ST_IT_WB, ST_II_MUL,
      ST_II_WB, ST_IDIFF2, ST_ID_MUL, ST_ID_WB
   } ctrl_state_type;

   typedef enum logic [3:0] {
      DP_NOP, DP_LOAD, DP_ERR, DP_DIFF, DP_DIFF2, DP_MUL, DP_WB, DP_INTEG,
      DP_DIV_INIT, DP_DIV_STEP, DP_RATE, DP_NEG, DP_SUM, DP_FF, DP_UPD, DP_PUT
   } dp_op_type;

   typedef enum logic [2:0] {
      MS_KP_ERR, MS_KP_DIFF, MS_ERR_PER, MS_KI_ISUM, MS_KI_ERR, MS_T_INC,
      MS_KD_T, MS_KD_DIFF
   } mul_sel_type;

   typedef enum logic [1:0] {
      DST_P, DST_I, DST_D, DST_T
   } dest_type;

   typedef struct packed {
      dp_op_type   op;
      mul_sel_type msel;
      dest_type    dest;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       div_last;
      logic       slot_free;
   } dp_status_type;

   function automatic logic signed [63:0] sx64(input logic signed [DATA_W-1:0] x);
      return {{(64 - DATA_W){x[DATA_W-1]}}, x};
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      if (v > S32_MAX_W) begin
         return 32'sh7FFF_FFFF;
      end else if (v < S32_MIN_W) begin
         return 32'sh8000_0000;
      end else begin
         return v[DATA_W-1:0];
      end
   endfunction

   // Above hi gives hi first; with crossed limits, a value above hi gives hi and any other gives lo.
   function automatic logic signed [DATA_W-1:0] clamp32(
      input logic signed [DATA_W-1:0] v,
      input logic signed [DATA_W-1:0] lo,
      input logic signed [DATA_W-1:0] hi);
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end else begin
         return v;
      end
   endfunction

endpackage
`default_nettype wire

FILE: hdl/mmpid_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Request channel of the PID controller: valid, ready and one sample.
// Depends on mmpid_pkg for the field widths.
interface mmpid_req_if;
   import mmpid_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [1:0]                mode;
   logic signed [DATA_W-1:0]  target;
   logic signed [DATA_W-1:0]  measured;
   logic signed [DATA_W-1:0]  feedforward;
   modport source(output valid, output mode, output target, output measured,
                  output feedforward, input ready);
   modport sink(input valid, input mode, input target, input measured,
                input feedforward, output ready);
endinterface
`default_nettype wire

FILE: hdl/mmpid_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Result channel of the PID controller: valid, ready, drive and accumulated.
// Depends on mmpid_pkg for the field widths.
interface mmpid_rsp_if;
   import mmpid_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [DATA_W-1:0]  drive;
   logic signed [DATA_W-1:0]  accumulated;
   modport source(output valid, output drive, output accumulated, input ready);
   modport sink(input valid, input drive, input accumulated, output ready);
endinterface
`default_nettype wire

FILE: hdl/mmpid_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequencer of the PID controller: steps the datapath through one request.
// Depends on mmpid_pkg for the state, command and status types.
module mmpid_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  mmpid_pkg::dp_status_type   sts,
   output mmpid_pkg::dp_cmd_type      cmd
);
   import mmpid_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_ERR;
         ST_ERR:      state_in = (sts.mode == MODE_INCREMENTAL) ? ST_IDIFF : ST_P_MUL;
         ST_P_MUL:    state_in = ST_P_WB;
         ST_P_WB:     state_in = ST_Q_MUL;
         ST_Q_MUL:    state_in = ST_Q_WB;
         ST_Q_WB:     state_in = ST_INTEG;
         ST_INTEG:    state_in = ST_I_MUL;
         ST_I_MUL:    state_in = ST_I_WB;
         ST_I_WB:     state_in = ST_DIFF;
         ST_DIFF:     state_in = ST_DIV_INIT;
         ST_DIV_INIT: state_in = ST_DIV_STEP;
         ST_DIV_STEP: if (sts.div_last) state_in = ST_RATE;
         ST_RATE:     state_in = ST_D_MUL;
         ST_D_MUL:    state_in = ST_D_WB;
         ST_D_WB:     state_in = (sts.mode == MODE_DERIV_MEAS) ? ST_NEG : ST_SUM;
         ST_NEG:      state_in = ST_SUM;
         ST_SUM:      state_in = (sts.mode == MODE_FEEDFWD) ? ST_FF : ST_UPD;
         ST_FF:       state_in = ST_UPD;
         ST_UPD:      state_in = ST_PUT;
         ST_PUT:      if (sts.slot_free) state_in = ST_IDLE;
         ST_IDIFF:    state_in = ST_IP_MUL;
         ST_IP_MUL:   state_in = ST_IP_WB;
         ST_IP_WB:    state_in = ST_IT_MUL;
         ST_IT_MUL:   state_in = ST_IT_WB;
         ST_IT_WB:    state_in = ST_II_MUL;
         ST_II_MUL:   state_in = ST_II_WB;
         ST_II_WB:    state_in = ST_IDIFF2;
         ST_IDIFF2:   state_in = ST_ID_MUL;
         ST_ID_MUL:   state_in = ST_ID_WB;
         ST_ID_WB:    state_in = ST_SUM;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = DP_NOP;
      cmd.msel  = MS_KP_ERR;
      cmd.dest  = DST_T;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = DP_LOAD;
         end
         ST_ERR:      cmd.op = DP_ERR;
         ST_P_MUL:    begin cmd.op = DP_MUL; cmd.msel = MS_KP_ERR;  end
         ST_P_WB:     begin cmd.op = DP_WB;  cmd.dest = DST_P;      end
         ST_Q_MUL:    begin cmd.op = DP_MUL; cmd.msel = MS_ERR_PER; end
         ST_Q_WB:     begin cmd.op = DP_WB;  cmd.dest = DST_T;      end
         ST_INTEG:    cmd.op = DP_INTEG;
         ST_I_MUL:    begin cmd.op = DP_MUL; cmd.msel = MS_KI_ISUM; end
         ST_I_WB:     begin cmd.op = DP_WB;  cmd.dest = DST_I;      end
         ST_DIFF:     cmd.op = DP_DIFF;
         ST_DIV_INIT: cmd.op = DP_DIV_INIT;
         ST_DIV_STEP: cmd.op = DP_DIV_STEP;
         ST_RATE:     cmd.op = DP_RATE;
         ST_D_MUL:    begin cmd.op = DP_MUL; cmd.msel = MS_KD_T;    end
         ST_D_WB:     begin cmd.op = DP_WB;  cmd.dest = DST_D;      end
         ST_NEG:      cmd.op = DP_NEG;
         ST_SUM:      cmd.op = DP_SUM;
         ST_FF:       cmd.op = DP_FF;
         ST_UPD:      cmd.op = DP_UPD;
         ST_PUT:      if (sts.slot_free) cmd.op = DP_PUT;
         ST_IDIFF:    cmd.op = DP_DIFF;
         ST_IP_MUL:   begin cmd.op = DP_MUL; cmd.msel = MS_KP_DIFF; end
         ST_IP_WB:    begin cmd.op = DP_WB;  cmd.dest = DST_P;      end
         ST_IT_MUL:   begin cmd.op = DP_MUL; cmd.msel = MS_KI_ERR;  end
         ST_IT_WB:    begin cmd.op = DP_WB;  cmd.dest = DST_T;      end
         ST_II_MUL:   begin cmd.op = DP_MUL; cmd.msel = MS_T_INC;   end
         ST_II_WB:    begin cmd.op = DP_WB;  cmd.dest = DST_I;      end
         ST_IDIFF2:   cmd.op = DP_DIFF2;
         ST_ID_MUL:   begin cmd.op = DP_MUL; cmd.msel = MS_KD_DIFF; end
         ST_ID_WB:    begin cmd.op = DP_WB;  cmd.dest = DST_D;      end
         default:     cmd.op = DP_NOP;
      endcase
   end

endmodule
`default_nettype wire

FILE: hdl/mmpid_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// Datapath of the PID controller: configuration registers, loop state, one
// shared 32x32 multiplier, a radix-2 divider and the result register.
// Depends on mmpid_pkg and mmpid_rsp_if.
module mmpid_dp (
   input  wire                                   clock,
   input  wire                                   reset,
   input  mmpid_pkg::dp_cmd_type                 cmd,
   output mmpid_pkg::dp_status_type              sts,
   input  wire [1:0]                             req_mode,
   input  wire signed [mmpid_pkg::DATA_W-1:0]    req_target,
   input  wire signed [mmpid_pkg::DATA_W-1:0]    req_measured,
   input  wire signed [mmpid_pkg::DATA_W-1:0]    req_feedforward,
   input  wire                                   csr_we,
   input  wire [mmpid_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [mmpid_pkg::DATA_W-1:0]           csr_wdata,
   mmpid_rsp_if.source                           rsp
);
   import mmpid_pkg::*;

   // Configuration.
   logic signed [DATA_W-1:0] kp_ff, ki_ff, kd_ff, hi_ff, lo_ff;
   logic [LIMIT_W-1:0]       lim_ff, per_ff;
   // Captured request.
   logic [1:0]               mode_ff, mode_in;
   logic signed [DATA_W-1:0] target_ff, target_in, meas_ff, meas_in, ffw_ff, ffw_in;
   // Working values.
   logic signed [DATA_W-1:0] err_ff, err_in, diff_ff, diff_in;
   logic signed [DATA_W-1:0] p_ff, p_in, i_ff, i_in, d_ff, d_in, t_ff, t_in;
   logic signed [DATA_W-1:0] drive_ff, drive_in;
   logic signed [63:0]       prod_ff, prod_in;
   // Loop state.
   logic signed [DATA_W-1:0] isum_ff, isum_in, last_ff, last_in;
   logic signed [DATA_W-1:0] older_ff, older_in, run_ff, run_in;
   // Divider.
   logic [DIV_STEPS-1:0]     num_ff, num_in, quo_ff, quo_in;
   logic [DATA_W-1:0]        rem_ff, rem_in;
   logic                     neg_ff, neg_in;
   logic [DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   // Result register.
   logic                     out_valid_ff, out_valid_in;
   logic signed [DATA_W-1:0] out_drive_ff, out_drive_in, out_acc_ff, out_acc_in;

   logic [LIMIT_W-1:0]       per_eff;
   logic signed [DATA_W-1:0] mul_a, mul_b, qres, lim_s, isum_new, mag;
   logic [DATA_W-1:0]        rem_sh;
   logic signed [63:0]       quo_s;

   assign per_eff = (per_ff == '0) ? LIMIT_W'(1) : per_ff;
   assign qres    = sat32(prod_ff >>> 16);
   assign lim_s   = {1'b0, lim_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff  <= '0;
         ki_ff  <= '0;
         kd_ff  <= '0;
         hi_ff  <= RST_OUTPUT_HIGH;
         lo_ff  <= RST_OUTPUT_LOW;
         lim_ff <= RST_LIMIT;
         per_ff <= RST_PERIOD;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PROP_GAIN:      kp_ff  <= csr_wdata;
            REG_INTEG_GAIN:     ki_ff  <= csr_wdata;
            REG_DERIV_GAIN:     kd_ff  <= csr_wdata;
            REG_OUTPUT_HIGH:    hi_ff  <= csr_wdata;
            REG_OUTPUT_LOW:     lo_ff  <= csr_wdata;
            REG_INTEGRAL_LIMIT: lim_ff <= csr_wdata[LIMIT_W-1:0];
            REG_SAMPLE_PERIOD:  per_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cmd.msel)
         MS_KP_ERR:  begin mul_a = kp_ff;  mul_b = err_ff;            end
         MS_KP_DIFF: begin mul_a = kp_ff;  mul_b = diff_ff;           end
         MS_ERR_PER: begin mul_a = err_ff; mul_b = {1'b0, per_eff};   end
         MS_KI_ISUM: begin mul_a = ki_ff;  mul_b = isum_ff;           end
         MS_KI_ERR:  begin mul_a = ki_ff;  mul_b = err_ff;            end
         MS_T_INC:   begin mul_a = t_ff;   mul_b = INC_GAIN;          end
         MS_KD_T:    begin mul_a = kd_ff;  mul_b = t_ff;              end
         MS_KD_DIFF: begin mul_a = kd_ff;  mul_b = diff_ff;           end
         default:    begin mul_a = kp_ff;  mul_b = err_ff;            end
      endcase
   end

   always_comb begin
      isum_new = clamp32(sat32(sx64(isum_ff) + sx64(t_ff)), -lim_s, lim_s);
      mag      = diff_ff[DATA_W-1] ? -diff_ff : diff_ff;
      rem_sh   = {rem_ff[DATA_W-2:0], num_ff[DIV_STEPS-1]};
      quo_s    = {{(64 - DIV_STEPS){1'b0}}, quo_ff};

      mode_in = mode_ff;   target_in = target_ff; meas_in = meas_ff; ffw_in = ffw_ff;
      err_in = err_ff;     diff_in = diff_ff;     p_in = p_ff;       i_in = i_ff;
      d_in = d_ff;         t_in = t_ff;           drive_in = drive_ff;
      prod_in = prod_ff;   num_in = num_ff;       quo_in = quo_ff;   rem_in = rem_ff;
      neg_in = neg_ff;     cnt_in = cnt_ff;
      isum_in = isum_ff;   last_in = last_ff;     older_in = older_ff; run_in = run_ff;
      out_drive_in = out_drive_ff;  out_acc_in = out_acc_ff;
      out_valid_in = out_valid_ff && !rsp.ready;

      case (cmd.op)
         DP_LOAD: begin
            mode_in = req_mode;  target_in = req_target;
            meas_in = req_measured;  ffw_in = req_feedforward;
         end
         DP_ERR:  err_in = sat32(sx64(target_ff) - sx64(meas_ff));
         DP_DIFF: begin
            if (mode_ff == MODE_DERIV_MEAS) begin
               diff_in = sat32(sx64(meas_ff) - sx64(older_ff));
            end else begin
               diff_in = sat32(sx64(err_ff) - sx64(last_ff));
            end
         end
         DP_DIFF2: diff_in = sat32(sx64(err_ff) - (sx64(last_ff) <<< 1) + sx64(older_ff));
         DP_MUL:   prod_in = sx64(mul_a) * sx64(mul_b);
         DP_WB: begin
            case (cmd.dest)
               DST_P:   p_in = qres;
               DST_I:   i_in = qres;
               DST_D:   d_in = qres;
               default: t_in = qres;
            endcase
         end
         DP_INTEG: isum_in = isum_new;
         DP_DIV_INIT: begin
            num_in = {mag, 16'h0000};
            rem_in = '0;
            quo_in = '0;
            neg_in = diff_ff[DATA_W-1];
            cnt_in = DIV_CNT_W'(DIV_STEPS);
         end
         DP_DIV_STEP: begin
            num_in = {num_ff[DIV_STEPS-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (rem_sh >= {1'b0, per_eff}) begin
               rem_in = rem_sh - {1'b0, per_eff};
               quo_in = {quo_ff[DIV_STEPS-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[DIV_STEPS-2:0], 1'b0};
            end
         end
         DP_RATE: t_in = sat32(neg_ff ? -quo_s : quo_s);
         DP_NEG:  d_in = sat32(-sx64(d_ff));
         DP_SUM:  drive_in = clamp32(sat32(sx64(p_ff) + sx64(i_ff) + sx64(d_ff)),
                                     lo_ff, hi_ff);
         DP_FF:   drive_in = clamp32(sat32(sx64(drive_ff) + sx64(ffw_ff)), lo_ff, hi_ff);
         DP_UPD: begin
            last_in = err_ff;
            case (mode_ff)
               MODE_INCREMENTAL: begin
                  older_in = last_ff;
                  run_in   = clamp32(sat32(sx64(run_ff) + sx64(drive_ff)), lo_ff, hi_ff);
               end
               MODE_DERIV_MEAS: older_in = meas_ff;
               default: ;
            endcase
         end
         DP_PUT: begin
            out_valid_in = 1'b1;
            out_drive_in = drive_ff;
            out_acc_in   = run_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;  target_ff <= target_in;  meas_ff <= meas_in;  ffw_ff <= ffw_in;
      err_ff <= err_in;    diff_ff <= diff_in;      p_ff <= p_in;        i_ff <= i_in;
      d_ff <= d_in;        t_ff <= t_in;            drive_ff <= drive_in;
      prod_ff <= prod_in;  num_ff <= num_in;        quo_ff <= quo_in;    rem_ff <= rem_in;
      neg_ff <= neg_in;    cnt_ff <= cnt_in;
      out_drive_ff <= out_drive_in;  out_acc_ff <= out_acc_in;
      if (reset) begin
         isum_ff      <= '0;
         last_ff      <= '0;
         older_ff     <= '0;
         run_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         isum_ff      <= isum_in;
         last_ff      <= last_in;
         older_ff     <= older_in;
         run_ff       <= run_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign sts.mode      = mode_ff;
   assign sts.div_last  = (cnt_ff == DIV_CNT_W'(1));
   assign sts.slot_free = !out_valid_ff || rsp.ready;

   assign rsp.valid       = out_valid_ff;
   assign rsp.drive       = out_drive_ff;
   assign rsp.accumulated = out_acc_ff;

endmodule
`default_nettype wire

FILE: hdl/multi_mode_pid_controller_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Multi-mode PID controller, Q16.16 signed throughout, saturating arithmetic.
// Requests arrive on req_chan (mode, target, measured, feedforward) and each
// gives exactly one result on rsp_chan (drive, accumulated), in order.
// Gains, output clamps, integral limit and sample period are written through
// csr_we/csr_index/csr_wdata only while the block is idle, a rule on the user that
// the block does not enforce; writes take effect at the edge where csr_we is high.
// The block works on one request at a time. A sequencer walks a datapath
// that owns one 32x32 multiplier and a one-bit-per-cycle divider. The
// positional mode runs the 48 divider steps for the rate term, which make up
// most of its sequence; derivative-on-measurement and feedforward modes add
// one step to it. The incremental mode needs no division.
// req_chan.ready is high only while the sequencer is idle, so the next request
// can be taken in the cycle after the previous result is written to the output
// register. A result waits in that register while the receiver stalls; the
// following request still runs and holds at its final step until the register
// frees up.
// A synchronous reset restores the register defaults, clears the integral,
// the error history and the running output, and empties the output register.
// Depends on mmpid_pkg, mmpid_req_if, mmpid_rsp_if, mmpid_ctrl and mmpid_dp.
module multi_mode_pid_controller_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   mmpid_req_if.sink                           req_chan,
   mmpid_rsp_if.source                         rsp_chan,
   input  wire                                 csr_we,
   input  wire [mmpid_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [mmpid_pkg::DATA_W-1:0]         csr_wdata
);
   import mmpid_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;
   logic          ctrl_ready;

   // The sequencer decides when a request is taken and which datapath step runs.
   mmpid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctrl_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath captures the request on its load step and owns the result register.
   mmpid_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_mode        (req_chan.mode),
      .req_target      (req_chan.target),
      .req_measured    (req_chan.measured),
      .req_feedforward (req_chan.feedforward),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp             (rsp_chan)
   );

   assign req_chan.ready = ctrl_ready;

   // Only one request is in flight: after one is taken, ready drops at once.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while another is in flight");

   // A waiting result stays valid and unchanged until the receiver takes it.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=>
         (rsp_chan.valid && $stable(rsp_chan.drive) && $stable(rsp_chan.accumulated)))
      else $error("waiting result changed before it was taken");

   // Reset leaves the block idle with no result pending.
   assert property (@(posedge clock)
      reset |=> (req_chan.ready && !rsp_chan.valid))
      else $error("block not idle after reset");

endmodule
`default_nettype wire
